[rtl/core/rslim_pkg.sv]
// ----------------------------------------------------------------------------
// rslim_pkg: shared types and constants of the rate limiter
// request and response beats, ring record, compare flags, sequencer states
// ----------------------------------------------------------------------------
package rslim_pkg;

    localparam int USER_W   = 64;
    localparam int TIME_W   = 32;
    localparam int WINDOW_W = 16;
    localparam int MAXREQ_W = 9;
    localparam int OUTC_W   = 2;
    localparam int MCOUNT_W = 9;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXREQ = 8'd1;

    // register reset values
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd60;
    localparam logic [MAXREQ_W-1:0] MAXREQ_RESET = 9'd120;

    // outcome codes
    localparam logic [OUTC_W-1:0] OUT_ALLOW  = 2'd0;
    localparam logic [OUTC_W-1:0] OUT_REJECT = 2'd1;
    localparam logic [OUTC_W-1:0] OUT_BYPASS = 2'd2;

    localparam logic [MCOUNT_W-1:0] MCOUNT_SAT = 9'd511;

    typedef struct packed {
        logic signed [USER_W-1:0] user_id;
        logic [TIME_W-1:0]        now_seconds;
    } req_t;

    typedef struct packed {
        logic [OUTC_W-1:0]   outcome;
        logic [MCOUNT_W-1:0] match_count;
    } rsp_t;

    typedef struct packed {
        logic [USER_W-1:0] user;
        logic [TIME_W-1:0] stamp;
    } rec_t;

    typedef struct packed {
        logic outside;
        logic hit;
    } cmp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVICT_RD,
        ST_EVICT_CHK,
        ST_SCAN,
        ST_DECIDE,
        ST_DONE
    } state_t;

endpackage

[rtl/core/rslim_ring.sv]
// ----------------------------------------------------------------------------
// rslim_ring: record ring storage
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module rslim_ring #(
    parameter int DEPTH = 256
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  rslim_pkg::rec_t            wr_rec,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output rslim_pkg::rec_t            rd_rec
);
    import rslim_pkg::*;

    rec_t mem [DEPTH];
    rec_t rd_rec_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_rec_reg <= mem[rd_addr];
    end

    assign rd_rec = rd_rec_reg;

endmodule

[rtl/core/rslim_cmp.sv]
// ----------------------------------------------------------------------------
// rslim_cmp: shared record compare unit
// age test against the window and user match, used by eviction and scan
// ----------------------------------------------------------------------------
module rslim_cmp (
    input  logic [rslim_pkg::TIME_W-1:0]   now_seconds,
    input  logic [rslim_pkg::WINDOW_W-1:0] window_seconds,
    input  logic [rslim_pkg::USER_W-1:0]   user,
    input  rslim_pkg::rec_t                rec,
    output rslim_pkg::cmp_t                flags
);
    import rslim_pkg::*;

    logic [TIME_W-1:0] age;
    logic              older;

    assign age   = now_seconds - rec.stamp;
    // a stamp in the future never ages out
    assign older = (now_seconds > rec.stamp) && (age > TIME_W'(window_seconds));

    assign flags.outside = older;
    assign flags.hit     = !older && (rec.user == user);

endmodule

[rtl/core/user_sliding_window_rate_limiter.sv]
// ----------------------------------------------------------------------------
// user_sliding_window_rate_limiter: per-user sliding window log limiter
// ring of (user, time) records walked by a small sequencer and one compare unit
// ----------------------------------------------------------------------------
// bypass requests go from accept straight to the response beat; checked requests
// evict aged records from the head, scan the records left for matches, decide,
// write the new record if allowed and then load the response beat
// one request at a time; req_stall stays high until the response is loaded
// reset clears head, record count and the response valid and sets both registers
// to their reset values; ring contents are not cleared, no clearing pass is needed
module user_sliding_window_rate_limiter #(
    parameter int RING_DEPTH = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               wr_en,
    input  logic [rslim_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [rslim_pkg::CFG_DATA_W-1:0]   wr_data,
    // request channel
    input  logic                               req_valid,
    output logic                               req_stall,
    input  rslim_pkg::req_t                    req,
    // response channel
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output rslim_pkg::rsp_t                    rsp
);
    import rslim_pkg::*;

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;
    localparam int MW    = (CNT_W > 10) ? CNT_W : 10;

    // slot arithmetic modulo ring depth, both operands below depth
    function automatic logic [IDX_W-1:0] wrap_add(
        input logic [IDX_W-1:0] a,
        input logic [IDX_W-1:0] b
    );
        logic [SUM_W-1:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= SUM_W'(RING_DEPTH))
        begin
            s = s - SUM_W'(RING_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    // sequencer and bookkeeping
    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic                 pend_reg, pend_next;
    logic [CNT_W-1:0]     match_reg, match_next;
    logic [USER_W-1:0]    user_reg, user_next;
    logic [TIME_W-1:0]    now_reg, now_next;
    logic [OUTC_W-1:0]    outc_reg, outc_next;

    // registers
    logic [WINDOW_W-1:0]  window_reg, window_next;
    logic [MAXREQ_W-1:0]  max_reg, max_next;

    // response stage
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;

    // ring and compare unit hookup
    logic                 ring_we;
    logic [IDX_W-1:0]     ring_waddr;
    rec_t                 ring_wrec;
    logic [IDX_W-1:0]     ring_raddr;
    rec_t                 ring_rrec;
    cmp_t                 cmp;

    logic                 req_beat;
    logic                 rsp_beat;
    logic                 bypass;
    logic                 scan_more;
    logic                 ring_full;
    logic                 rsp_free;
    logic [IDX_W-1:0]     scan_slot;
    logic [IDX_W-1:0]     head_inc;
    logic [MW-1:0]        match_ext;

    assign req_beat  = req_valid && !req_stall;
    assign rsp_beat  = rsp_valid_reg && !rsp_stall;
    // ids at or below zero skip the limiter
    assign bypass    = req.user_id[USER_W-1] || (req.user_id == '0);
    assign scan_more = idx_reg < count_reg;
    assign ring_full = count_reg == CNT_W'(RING_DEPTH);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign scan_slot = wrap_add(head_reg, idx_reg[IDX_W-1:0]);
    assign head_inc  = wrap_add(head_reg, IDX_W'(1));
    assign match_ext = MW'(match_reg);

    rslim_ring #(
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_we),
        .wr_addr (ring_waddr),
        .wr_rec  (ring_wrec),
        .rd_addr (ring_raddr),
        .rd_rec  (ring_rrec)
    );

    // one compare unit serves both the eviction check and the scan
    rslim_cmp u_cmp (
        .now_seconds    (now_reg),
        .window_seconds (window_reg),
        .user           (user_reg),
        .rec            (ring_rrec),
        .flags          (cmp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_beat)
                begin
                    state_next = bypass ? ST_DONE : ST_EVICT_RD;
                end
            end
            ST_EVICT_RD:
            begin
                state_next = (count_reg == '0) ? ST_SCAN : ST_EVICT_CHK;
            end
            ST_EVICT_CHK:
            begin
                state_next = cmp.outside ? ST_EVICT_RD : ST_SCAN;
            end
            ST_SCAN:
            begin
                // finish once all reads are issued and the last one is checked
                if (!scan_more && !pend_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        req_stall      = 1'b1;
        ring_we        = 1'b0;
        ring_waddr     = wrap_add(head_reg, count_reg[IDX_W-1:0]);
        ring_wrec.user = user_reg;
        ring_wrec.stamp = now_reg;
        ring_raddr     = head_reg;

        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        match_next     = match_reg;
        user_next      = user_reg;
        now_next       = now_reg;
        outc_next      = outc_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_beat;
        rsp_next       = rsp_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_beat)
                begin
                    user_next  = req.user_id;
                    now_next   = req.now_seconds;
                    match_next = '0;
                    outc_next  = OUT_BYPASS;
                end
            end
            ST_EVICT_RD:
            begin
                ring_raddr = head_reg;
                idx_next   = '0;
            end
            ST_EVICT_CHK:
            begin
                idx_next = '0;
                if (cmp.outside)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_SCAN:
            begin
                ring_raddr = scan_slot;
                if (scan_more)
                begin
                    idx_next  = idx_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg && cmp.hit)
                begin
                    match_next = match_reg + CNT_W'(1);
                end
            end
            ST_DECIDE:
            begin
                if (match_ext >= MW'(max_reg))
                begin
                    outc_next = OUT_REJECT;
                end
                else
                begin
                    outc_next = OUT_ALLOW;
                    ring_we   = 1'b1;
                    if (ring_full)
                    begin
                        // overwrite the oldest record
                        ring_waddr = head_reg;
                        head_next  = head_inc;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.outcome    = outc_reg;
                    rsp_next.match_count = (match_ext > MW'(MCOUNT_SAT)) ?
                                           MCOUNT_SAT : match_ext[MCOUNT_W-1:0];
                end
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // register decode, ignores unknown indexes
    always_comb
    begin
        window_next = window_reg;
        max_next    = max_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_WINDOW: window_next = wr_data[WINDOW_W-1:0];
                CFG_MAXREQ: max_next    = wr_data[MAXREQ_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            window_reg    <= WINDOW_RESET;
            max_reg       <= MAXREQ_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            window_reg    <= window_next;
            max_reg       <= max_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
        user_reg  <= user_next;
        now_reg   <= now_next;
        outc_reg  <= outc_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[rtl/core/rslim_chk.sv]
// ----------------------------------------------------------------------------
// rslim_chk: port-level checker for the rate limiter
// watches the request and response channels, bound to the top level
// ----------------------------------------------------------------------------
module rslim_chk (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_stall,
    input rslim_pkg::rsp_t rsp,
    input logic            rsp_valid,
    input logic            rsp_stall
);
    import rslim_pkg::*;

    // a stalled response beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response beat changed");

    // one request at a time: after an accepted beat the block stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while one in flight");

    // bypassed requests report no matches
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.outcome == OUT_BYPASS) |-> rsp.match_count == '0)
        else $error("bypass beat with nonzero match count");

    // a new response beat only appears right after the request side was stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("response appeared without request in flight");

endmodule

bind user_sliding_window_rate_limiter rslim_chk u_rslim_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
);
